@@ sv/ghs_pkg.sv @@
package ghs_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int NUM_BINS    = 256;
  localparam int BIN_IDX_W   = 8;
  localparam int PIX_W       = 8;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 40;
  localparam int D_W         = 62;
  localparam int DIV_W       = 80;
  localparam int DIV_STEPS   = 80;
  localparam int DIV_CNT_W   = 7;
  localparam int FQ_DEPTH    = 4;
  localparam int FQ_PTR_W    = 2;
  localparam int FQ_CNT_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int LIM_W       = 8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;

  localparam logic [LIM_W-1:0] DARK_RST       = 8'd85;
  localparam logic [LIM_W-1:0] MED_LIGHT_RST  = 8'd170;
  localparam logic [LIM_W-1:0] LOW_CONT_RST   = 8'd30;
  localparam logic [LIM_W-1:0] MED_CONT_RST   = 8'd70;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MED_LIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CONT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MED_CONT  = 3'd3;

  localparam logic KIND_STATS = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  localparam logic [1:0] CLASS_LOW  = 2'd0;
  localparam logic [1:0] CLASS_MID  = 2'd1;
  localparam logic [1:0] CLASS_HIGH = 2'd2;

  typedef enum logic [1:0] {CMD_PUSH, CMD_PUSH_LAST, CMD_READ} cmd_t;

  typedef enum logic [2:0] {B_IDLE, B_UPD, B_RD, B_MATH, B_STAT} back_state_t;

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_DIV, M_SQRT, M_DONE} math_state_t;

  typedef enum logic [1:0] {DIV_MEAN, DIV_Q1, DIV_Q2} div_sel_t;

  typedef struct packed {
    logic                 operation;
    logic [PIX_W-1:0]     pixel_value;
    logic                 last_pixel;
    logic [BIN_IDX_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [15:0]            mean_q8;
    logic [14:0]            stddev_q8;
    logic [1:0]             brightness_class;
    logic [1:0]             contrast_class;
    logic [COUNT_WIDTH-1:0] frame_pixels;
    logic [COUNT_WIDTH-1:0] bin_count;
    logic                   count_overflow;
  } out_item_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [PIX_W-1:0]     pix;
    logic [BIN_IDX_W-1:0] idx;
  } fq_item_t;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic                   clr;
    logic [BIN_IDX_W-1:0]   addr;
    logic [COUNT_WIDTH-1:0] wdata;
  } hist_req_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] n;
    logic [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]        sumsq;
    logic [LIM_W-1:0]       dark;
    logic [LIM_W-1:0]       med_light;
    logic [LIM_W-1:0]       low_cont;
    logic [LIM_W-1:0]       med_cont;
  } math_in_t;

  typedef struct packed {
    logic [15:0] mean;
    logic [14:0] stddev;
    logic [1:0]  bright;
    logic [1:0]  contrast;
  } math_out_t;

endpackage

@@ sv/ghs_front.sv @@
module ghs_front import ghs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic     pop,
  output logic     head_valid,
  output fq_item_t head
);

  fq_item_t              fq_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FQ_CNT_W-1:0]   cnt_r;
  logic                  push;
  logic                  do_pop;
  fq_item_t              cls;

  // classify on the way in
  always_comb begin
    cls.pix = in_item.pixel_value;
    cls.idx = in_item.bin_index;
    if (in_item.operation) begin
      cls.cmd = CMD_READ;
    end else if (in_item.last_pixel) begin
      cls.cmd = CMD_PUSH_LAST;
    end else begin
      cls.cmd = CMD_PUSH;
    end
  end

  assign in_stall   = (cnt_r == FQ_CNT_W'(FQ_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = fq_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fq_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + FQ_CNT_W'(push) - FQ_CNT_W'(do_pop);
    end
  end

endmodule

@@ sv/ghs_hist.sv @@
module ghs_hist import ghs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hist_req_t              req,
  output logic [COUNT_WIDTH-1:0] rdata
);

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    vld_r;
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic                   rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  // per-bin valid bits; frame start clears all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= !req.clr && vld_r[req.addr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

@@ sv/ghs_math.sv @@
module ghs_math import ghs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  math_in_t  args,
  output logic      busy,
  output logic      done,
  output math_out_t res
);

  math_state_t state_r, state_nxt;

  math_in_t               a_r;
  logic [2:0]             step_r;
  logic [63:0]            prod_r, acc_r;
  logic [D_W-1:0]         d_r;
  logic                   lt_dark_r;
  logic [1:0]             bright_r, contrast_r;
  div_sel_t               sel_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [DIV_W-1:0]       q_r;
  logic [15:0]            mean_r;
  logic [31:0]            x_r, r_r, b_r;

  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p;
  logic [COUNT_WIDTH:0]   t;
  logic                   ge;
  logic [COUNT_WIDTH-1:0] rem_nxt;
  logic [DIV_W-1:0]       q_nxt;
  logic                   div_last;
  logic [31:0]            rb;
  logic [15:0]            low2, med2, var_int;
  logic                   mul_last, sqrt_last;

  // shared multiplier operands per step
  always_comb begin
    case (step_r)
      3'd0: begin mul_a = 32'(a_r.n); mul_b = a_r.sumsq[31:0]; end
      3'd1: begin mul_a = 32'(a_r.n); mul_b = 32'(a_r.sumsq[SQ_W-1:32]); end
      3'd2: begin mul_a = a_r.sum; mul_b = a_r.sum; end
      3'd3: begin mul_a = 32'(a_r.n); mul_b = 32'(a_r.dark); end
      3'd4: begin mul_a = 32'(a_r.n); mul_b = 32'(a_r.med_light); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // restoring divide step, divisor n
  assign t        = {rem_r, q_r[DIV_W-1]};
  assign ge       = (t >= {1'b0, a_r.n});
  assign rem_nxt  = ge ? COUNT_WIDTH'(t - {1'b0, a_r.n}) : t[COUNT_WIDTH-1:0];
  assign q_nxt    = {q_r[DIV_W-2:0], ge};
  assign div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  assign rb        = r_r + b_r;
  assign low2      = 16'(a_r.low_cont) * 16'(a_r.low_cont);
  assign med2      = 16'(a_r.med_cont) * 16'(a_r.med_cont);
  assign var_int   = {1'b0, q_nxt[30:16]};
  assign mul_last  = (step_r == 3'd5);
  assign sqrt_last = (b_r == 32'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE: if (start) state_nxt = M_MUL;
      M_MUL:  if (mul_last) state_nxt = M_DIV;
      M_DIV:  if (div_last && sel_r == DIV_Q2) state_nxt = M_SQRT;
      M_SQRT: if (sqrt_last) state_nxt = M_DONE;
      M_DONE: state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_r != M_IDLE);
    done          = (state_r == M_DONE);
    res.mean      = mean_r;
    res.stddev    = r_r[14:0];
    res.bright    = bright_r;
    res.contrast  = contrast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (start) begin
          a_r    <= args;
          step_r <= '0;
        end
      end
      M_MUL: begin
        prod_r <= mul_p;
        step_r <= step_r + 1'b1;
        case (step_r)
          3'd1: acc_r <= prod_r;
          3'd2: acc_r <= acc_r + {prod_r[31:0], 32'b0};
          3'd3: d_r <= D_W'(acc_r - prod_r);
          3'd4: lt_dark_r <= (a_r.sum < prod_r[31:0]);
          3'd5: begin
            if (lt_dark_r) bright_r <= CLASS_LOW;
            else if (a_r.sum < prod_r[31:0]) bright_r <= CLASS_MID;
            else bright_r <= CLASS_HIGH;
            sel_r <= DIV_MEAN;
            cnt_r <= '0;
            rem_r <= '0;
            q_r   <= DIV_W'({a_r.sum, 8'b0});
          end
          default: ;
        endcase
      end
      M_DIV: begin
        if (!div_last) begin
          cnt_r <= cnt_r + 1'b1;
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
        end else begin
          cnt_r <= '0;
          rem_r <= '0;
          case (sel_r)
            DIV_MEAN: begin
              mean_r <= q_nxt[15:0];
              q_r    <= DIV_W'({d_r, 16'b0});
              sel_r  <= DIV_Q1;
            end
            DIV_Q1: begin
              q_r   <= q_nxt;
              sel_r <= DIV_Q2;
            end
            default: begin
              // variance floor against squared limits
              if (var_int < low2) contrast_r <= CLASS_LOW;
              else if (var_int < med2) contrast_r <= CLASS_MID;
              else contrast_r <= CLASS_HIGH;
              x_r <= {1'b0, q_nxt[30:0]};
              r_r <= '0;
              b_r <= 32'h4000_0000;
            end
          endcase
        end
      end
      M_SQRT: begin
        if (x_r >= rb) begin
          x_r <= x_r - rb;
          r_r <= {1'b0, r_r[31:1]} + b_r;
        end else begin
          r_r <= {1'b0, r_r[31:1]};
        end
        b_r <= {2'b0, b_r[31:2]};
      end
      default: ;
    endcase
  end

endmodule

@@ sv/gray_histogram_statistics_top.sv @@
// Gray histogram statistics block.
// in channel (in_valid / in_stall / in_item): one item per handshake, either a
// pixel push or a bin readback request. The item is taken at a clock edge with
// in_valid high and in_stall low. A 4-entry queue sits in front.
// out channel (out_valid / out_stall / out_item): frame statistics on the push
// marked last_pixel, or a bin count for a readback request. Pushes that are not
// last give no result. The output register holds its item while out_stall.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata): the four class
// thresholds, written only while the block is idle: a user rule the block
// does not enforce; cfg_ready is always high. A pixel push is a read, then a
// write of the histogram bin: single-port read-modify-write on the bin RAM.
// A readback is a read, then the output load. Closing a frame runs steps on
// the shared multiplier, three 80-step divisions by the pixel count and a
// 16-step square root. The queue keeps accepting while the back end works.
// Reset (synchronous, rst_n low) empties the queue, clears the bin valid bits,
// the counters and the frame flag, and loads threshold defaults. No sweep.
module gray_histogram_statistics_top import ghs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_wdata
);

  back_state_t state_r, state_nxt;

  // thresholds
  logic [LIM_W-1:0] dark_r, med_light_r, low_cont_r, med_cont_r;

  // frame accumulators
  logic [COUNT_WIDTH-1:0] total_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]        sumsq_r;
  logic                   frame_open_r;
  logic                   overflow_r;
  logic [PIX_W-1:0]       pix_r;
  logic                   last_r;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  // front / back links
  logic       head_valid;
  fq_item_t   head;
  logic       pop;
  hist_req_t  hist_req;
  logic [COUNT_WIDTH-1:0] bin_rdata;
  logic       math_start, math_busy, math_done;
  math_in_t   math_args;
  math_out_t  math_res;

  // back end controls
  logic                   is_push;
  logic                   new_frame;
  logic [COUNT_WIDTH-1:0] eff_total;
  logic                   can_count;
  logic                   stat_add;
  logic                   ovf_set;
  logic                   close_frame;
  logic                   out_free;
  logic                   load_stats, load_bin;
  logic [15:0]            pix_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r      <= DARK_RST;
      med_light_r <= MED_LIGHT_RST;
      low_cont_r  <= LOW_CONT_RST;
      med_cont_r  <= MED_CONT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DARK:      dark_r      <= cfg_wdata;
        CFG_MED_LIGHT: med_light_r <= cfg_wdata;
        CFG_LOW_CONT:  low_cont_r  <= cfg_wdata;
        CFG_MED_CONT:  med_cont_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ghs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ghs_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rdata (bin_rdata)
  );

  always_comb begin
    math_args.n         = total_r;
    math_args.sum       = sum_r;
    math_args.sumsq     = sumsq_r;
    math_args.dark      = dark_r;
    math_args.med_light = med_light_r;
    math_args.low_cont  = low_cont_r;
    math_args.med_cont  = med_cont_r;
  end

  ghs_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .start (math_start),
    .args  (math_args),
    .busy  (math_busy),
    .done  (math_done),
    .res   (math_res)
  );

  // A push that finds no open frame starts one: counters read as zero.
  assign is_push   = (head.cmd != CMD_READ);
  assign new_frame = !frame_open_r;
  assign eff_total = new_frame ? '0 : total_r;
  assign can_count = (eff_total != COUNT_LIMIT);
  assign out_free  = !out_valid_r || !out_stall;
  assign pix_sq    = 16'(head.pix) * 16'(head.pix);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          if (!is_push) state_nxt = B_RD;
          else if (can_count) state_nxt = B_UPD;
          else if (head.cmd == CMD_PUSH_LAST) state_nxt = B_MATH;
          else state_nxt = B_IDLE;
        end
      end
      B_UPD:  state_nxt = last_r ? B_MATH : B_IDLE;
      B_RD:   if (out_free) state_nxt = B_IDLE;
      B_MATH: if (math_done) state_nxt = B_STAT;
      B_STAT: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // controls
  always_comb begin
    pop            = 1'b0;
    hist_req       = '0;
    stat_add       = 1'b0;
    ovf_set        = 1'b0;
    close_frame    = 1'b0;
    load_stats     = 1'b0;
    load_bin       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (!is_push) begin
            hist_req.rd_en = 1'b1;
            hist_req.addr  = head.idx;
          end else begin
            hist_req.clr = new_frame;
            if (can_count) begin
              stat_add       = 1'b1;
              hist_req.rd_en = 1'b1;
              hist_req.addr  = head.pix;
            end else begin
              ovf_set     = 1'b1;
              close_frame = (head.cmd == CMD_PUSH_LAST);
            end
          end
        end
      end
      B_UPD: begin
        hist_req.wr_en = 1'b1;
        hist_req.addr  = pix_r;
        hist_req.wdata = bin_rdata + 1'b1;
        close_frame    = last_r;
      end
      B_RD:   load_bin   = out_free;
      B_STAT: load_stats = out_free;
      default: ;
    endcase
  end

  assign math_start = close_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      total_r      <= '0;
      sum_r        <= '0;
      sumsq_r      <= '0;
      frame_open_r <= 1'b0;
      overflow_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a frame-opening push always counts, so the sums restart from zero below
      if (pop && is_push && new_frame) begin
        frame_open_r <= 1'b1;
        overflow_r   <= 1'b0;
      end
      if (stat_add) begin
        total_r <= eff_total + 1'b1;
        sum_r   <= (new_frame ? '0 : sum_r) + SUM_W'(head.pix);
        sumsq_r <= (new_frame ? '0 : sumsq_r) + SQ_W'(pix_sq);
      end
      if (ovf_set) overflow_r <= 1'b1;
      if (close_frame) frame_open_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r  <= head.pix;
      last_r <= (head.cmd == CMD_PUSH_LAST);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_stats || load_bin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_stats) begin
      out_item_r.result_kind      <= KIND_STATS;
      out_item_r.mean_q8          <= math_res.mean;
      out_item_r.stddev_q8        <= math_res.stddev;
      out_item_r.brightness_class <= math_res.bright;
      out_item_r.contrast_class   <= math_res.contrast;
      out_item_r.frame_pixels     <= total_r;
      out_item_r.bin_count        <= '0;
      out_item_r.count_overflow   <= overflow_r;
    end else if (load_bin) begin
      out_item_r.result_kind      <= KIND_BIN;
      out_item_r.mean_q8          <= '0;
      out_item_r.stddev_q8        <= '0;
      out_item_r.brightness_class <= CLASS_LOW;
      out_item_r.contrast_class   <= CLASS_LOW;
      out_item_r.frame_pixels     <= total_r;
      out_item_r.bin_count        <= bin_rdata;
      out_item_r.count_overflow   <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // overflow only once the count is pinned at its limit
  a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> (total_r == COUNT_LIMIT))
    else $error("overflow flag without full count");

  // the divider sequence is never restarted while running
  a_math_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    math_start |-> !math_busy)
    else $error("math start while busy");

  // bin writes only in the update state
  a_wr_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
    hist_req.wr_en |-> (state_r == B_UPD))
    else $error("histogram write outside update");

  // a loaded statistics result shows up as a statistics item
  a_stats_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_stats |=> (out_valid && out_item.result_kind == KIND_STATS))
    else $error("statistics result lost");

endmodule

@@ bench/tb_gray_histogram_statistics_top.sv @@
module tb_gray_histogram_statistics_top import ghs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // operation field codes of an input item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0]     cfg_wdata;

  gray_histogram_statistics_top dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: histogram, running sums, frame flags, thresholds.
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] hist_bins [NUM_BINS];
  logic [COUNT_WIDTH-1:0] pix_total;
  logic [SUM_W-1:0]       pix_sum;
  logic [SQ_W-1:0]        pix_sqsum;
  logic                   frame_busy;
  logic                   dropped;
  logic [LIM_W-1:0]       lim_dark, lim_med_light, lim_low_cont, lim_med_cont;

  out_item_t expected_stats[$];   // results still owed by the block
  int        mismatches;
  bit        no_idle;              // stretch with no gaps and no stalls
  int        stall_left;
  bit        rearm_stall;

  // integer square root, floor
  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Advance the shadow by one accepted item; queue the result it causes.
  task automatic track_item(in_item_t it);
    out_item_t   r;
    logic [127:0] n, nn, dev, lo_t, hi_t;
    r = '0;
    if (it.operation == OP_READ) begin
      r.result_kind    = KIND_BIN;
      r.frame_pixels   = pix_total;
      r.bin_count      = hist_bins[it.bin_index];
      r.count_overflow = dropped;
      expected_stats.push_back(r);
      return;
    end
    // first push after a closed frame starts a fresh one
    if (!frame_busy) begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      pix_total  = '0;
      pix_sum    = '0;
      pix_sqsum  = '0;
      dropped    = 1'b0;
      frame_busy = 1'b1;
    end
    if (pix_total != COUNT_LIMIT) begin
      hist_bins[it.pixel_value]++;
      pix_total++;
      pix_sum   = pix_sum + it.pixel_value;
      pix_sqsum = pix_sqsum + SQ_W'(it.pixel_value) * SQ_W'(it.pixel_value);
    end else begin
      dropped = 1'b1;
    end
    if (!it.last_pixel) return;
    frame_busy = 1'b0;
    r.result_kind = KIND_STATS;
    n = 128'(pix_total);
    if (n != 0) begin
      nn  = n * n;
      // n^2 * variance, exact
      dev = n * 128'(pix_sqsum) - 128'(pix_sum) * 128'(pix_sum);
      r.mean_q8   = 16'(({96'b0, pix_sum} << 8) / n);
      r.stddev_q8 = 15'(sqrt_floor(64'((dev << 16) / nn)));
      if (128'(pix_sum) < 128'(lim_dark) * n)            r.brightness_class = CLASS_LOW;
      else if (128'(pix_sum) < 128'(lim_med_light) * n)  r.brightness_class = CLASS_MID;
      else                                               r.brightness_class = CLASS_HIGH;
      // stddev < L  <=>  dev < L^2 n^2
      lo_t = nn * 128'(lim_low_cont) * 128'(lim_low_cont);
      hi_t = nn * 128'(lim_med_cont) * 128'(lim_med_cont);
      if (dev < lo_t)      r.contrast_class = CLASS_LOW;
      else if (dev < hi_t) r.contrast_class = CLASS_MID;
      else                 r.contrast_class = CLASS_HIGH;
    end
    r.frame_pixels   = pix_total;
    r.count_overflow = dropped;
    expected_stats.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, stimulus helpers
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One item: optional random gap, then hold until taken.
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_item  = in_item_t'($urandom);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    track_item(it);
  endtask

  task automatic push_pixel(logic [7:0] pix, logic last);
    in_item_t it;
    it = in_item_t'($urandom);      // unused bits random
    it.operation   = OP_PUSH;
    it.pixel_value = pix;
    it.last_pixel  = last;
    send_item(it);
  endtask

  task automatic read_bin(logic [7:0] idx);
    in_item_t it;
    it = in_item_t'($urandom);
    it.operation = OP_READ;
    it.bin_index = idx;
    send_item(it);
  endtask

  // Drain: all results in, then room for a frame close still running.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_DARK:      lim_dark      = val;
      CFG_MED_LIGHT: lim_med_light = val;
      CFG_LOW_CONT:  lim_low_cont  = val;
      CFG_MED_CONT:  lim_med_cont  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(logic [7:0] d, logic [7:0] ml, logic [7:0] lc, logic [7:0] mc);
    wait_quiet();
    write_limit(CFG_DARK, d);
    write_limit(CFG_MED_LIGHT, ml);
    write_limit(CFG_LOW_CONT, lc);
    write_limit(CFG_MED_CONT, mc);
  endtask

  // A frame of random length. Spread picks the pixel distribution so that
  // low, medium and high contrast all show up.
  task automatic random_frame(int len, int read_pct);
    int center, spread;
    logic [7:0] p;
    center = $urandom_range(0, 255);
    spread = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 90);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < read_pct) read_bin(8'($urandom_range(0, 255)));
      if (spread == 255) p = 8'($urandom_range(0, 255));
      else p = 8'(center + $urandom_range(0, 2 * spread) - spread);
      push_pixel(p, k == len - 1);
    end
    // look at a few bins of the closed frame
    if ($urandom_range(0, 1)) begin
      read_bin(p);
      read_bin(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    read_bin(8'd0);                  // empty histogram after reset
    push_pixel(8'd0, 1'b1);          // one-pixel frame, black
    read_bin(8'd0);
    read_bin(8'd255);
    push_pixel(8'd255, 1'b1);        // one-pixel frame, white
    push_pixel(8'd0, 1'b0);          // widest spread
    push_pixel(8'd255, 1'b0);
    read_bin(8'd255);                // partial counts of an open frame
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b1);
    read_bin(8'd0);                  // histogram held after the frame ends
    read_bin(8'd170);
    push_pixel(8'd85, 1'b0);         // mean right at the dark limit
    push_pixel(8'd85, 1'b1);
    push_pixel(8'd170, 1'b0);        // mean right at the medium limit
    push_pixel(8'd170, 1'b1);
    push_pixel(8'd55, 1'b0);         // stddev exactly 30
    push_pixel(8'd115, 1'b1);
    push_pixel(8'd100, 1'b0);        // stddev exactly 70
    push_pixel(8'd240, 1'b1);
    read_bin(8'hAA);
    read_bin(8'h55);
  endtask

  task automatic test_limit_sweep();
    set_limits(8'd0, 8'd0, 8'd0, 8'd0);
    repeat (6) random_frame($urandom_range(1, 12), 10);
    set_limits(8'd255, 8'd255, 8'd128, 8'd128);
    repeat (6) random_frame($urandom_range(1, 12), 10);
    set_limits(8'd255, 8'd0, 8'd128, 8'd0);        // crossed limits
    repeat (6) random_frame($urandom_range(1, 12), 10);
    set_limits(8'd1, 8'd254, 8'd1, 8'd127);
    repeat (6) random_frame($urandom_range(1, 12), 10);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 1000) begin
      if ($urandom_range(0, 7) == 0)
        set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)));
      if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 9) == 0) begin
        random_frame($urandom_range(60, 150), 5);
        sent += 100;
      end else begin
        random_frame($urandom_range(1, 20), 15);
        sent += 12;
      end
    end
    no_idle = 1'b0;
    set_limits(DARK_RST, MED_LIGHT_RST, LOW_CONT_RST, MED_CONT_RST);
    repeat (4) random_frame($urandom_range(1, 16), 10);
  endtask

  // ---------------------------------------------------------------------------
  // Result stall: a random hold after each result, none in quiet stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0 && !no_idle) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall  = 1'b0;
      stall_left = 0;
      if (rearm_stall) begin
        stall_left  = $urandom_range(0, 6);
        rearm_stall = 1'b0;
      end
    end
  end

  // Result checker: each taken result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      rearm_stall = 1'b1;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = expected_stats.pop_front();
        if (out_item.result_kind      !== want.result_kind      ||
            out_item.mean_q8          !== want.mean_q8          ||
            out_item.stddev_q8        !== want.stddev_q8        ||
            out_item.brightness_class !== want.brightness_class ||
            out_item.contrast_class   !== want.contrast_class   ||
            out_item.frame_pixels     !== want.frame_pixels     ||
            out_item.bin_count        !== want.bin_count        ||
            out_item.count_overflow   !== want.count_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    rearm_stall = 1'b0;
    no_idle     = 1'b0;
    mismatches  = 0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    pix_total     = '0;
    pix_sum       = '0;
    pix_sqsum     = '0;
    frame_busy    = 1'b0;
    dropped       = 1'b0;
    lim_dark      = DARK_RST;
    lim_med_light = MED_LIGHT_RST;
    lim_low_cont  = LOW_CONT_RST;
    lim_med_cont  = MED_CONT_RST;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_limit_sweep();
    test_random_frames();
    wait_quiet();

    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ghs_pkg.sv
sv/ghs_front.sv
sv/ghs_hist.sv
sv/ghs_math.sv
sv/gray_histogram_statistics_top.sv
bench/tb_gray_histogram_statistics_top.sv
